// ===== hw/rtl/dtpz_pkg.sv =====
`timescale 1ns / 1ps
package dtpz_pkg;

    localparam int FRAC_BITS  = 24;
    localparam int Z_W        = FRAC_BITS + 1;
    localparam int IDX_W      = 20;
    localparam int DEPTH_W    = 13;
    localparam int CLIP_W     = 16;
    localparam int SIZE_W     = 11;
    localparam int ROW_W      = 10;
    localparam int COL_W      = 10;
    localparam int NUM_W      = CLIP_W + DEPTH_W;
    localparam int REM_W      = NUM_W + 1;
    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;
    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 48;

    typedef enum logic [1:0] {
        REG_NEAR   = 2'd0,
        REG_FAR    = 2'd1,
        REG_WIDTH  = 2'd2,
        REG_HEIGHT = 2'd3
    } reg_idx_t;

    // per-item fields that ride along with the quotient
    typedef struct packed {
        logic             special;
        logic             spec_one;
        logic             err;
        logic [IDX_W-1:0] idx;
    } side_t;

    typedef struct packed {
        logic [Z_W-1:0]   z;
        logic [IDX_W-1:0] idx;
        logic             err;
    } result_t;

endpackage

// ===== hw/rtl/dtpz_prep.sv =====
`timescale 1ns / 1ps
module dtpz_prep
    import dtpz_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                en,
    input  logic                in_valid,
    input  logic [15:0]         depth_raw,
    input  logic [ROW_W-1:0]    pixel_row,
    input  logic [COL_W-1:0]    pixel_col,
    input  logic [CLIP_W-1:0]   near_mm,
    input  logic [CLIP_W-1:0]   far_mm,
    input  logic [SIZE_W-1:0]   image_width,
    input  logic [SIZE_W-1:0]   image_height,
    output logic                out_valid,
    output logic [NUM_W-1:0]    out_num,
    output logic [NUM_W-1:0]    out_den,
    output side_t               out_side
);

    localparam logic [SIZE_W-1:0] WMAX = SIZE_W'(MAX_WIDTH);
    localparam logic [SIZE_W-1:0] HMAX = SIZE_W'(MAX_HEIGHT);

    // stage 1
    logic                v1_reg;
    logic [DEPTH_W-1:0]  d1_reg;
    logic [DEPTH_W-1:0]  dmn1_reg;
    logic [CLIP_W-1:0]   far1_reg;
    logic [CLIP_W-1:0]   fmn1_reg;
    logic [IDX_W-1:0]    hr1_reg;
    logic [SIZE_W-1:0]   w1_reg;
    logic [COL_W-1:0]    col1_reg;
    logic                sp1_reg, one1_reg, err1_reg;
    // stage 2
    logic                v2_reg;
    logic [NUM_W-1:0]    num2_reg, den2_reg;
    logic [IDX_W-1:0]    idxm2_reg;
    logic [COL_W-1:0]    col2_reg;
    logic                sp2_reg, one2_reg, err2_reg;
    // stage 3
    logic                v3_reg;
    logic [NUM_W-1:0]    num3_reg, den3_reg;
    side_t               side3_reg;

    logic [DEPTH_W-1:0]  d_next;
    logic                err_next, dz_next, le_next, ge_next;
    logic [SIZE_W-1:0]   w_next, h_next;
    logic [IDX_W-1:0]    hr_next;
    logic [IDX_W+SIZE_W-1:0] idx_prod;

    always_comb begin
        d_next   = depth_raw[15:3];
        err_next = far_mm <= near_mm;
        dz_next  = d_next == '0;
        le_next  = {3'b000, d_next} <= near_mm;
        ge_next  = {3'b000, d_next} >= far_mm;
        w_next   = (image_width > WMAX) ? WMAX : image_width;
        h_next   = (image_height > HMAX) ? HMAX : image_height;
        hr_next  = {{(IDX_W-SIZE_W){1'b0}}, h_next} - IDX_W'(1)
                 - {{(IDX_W-ROW_W){1'b0}}, pixel_row};
        idx_prod = hr1_reg * w1_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            d1_reg    <= d_next;
            dmn1_reg  <= d_next - near_mm[DEPTH_W-1:0];
            far1_reg  <= far_mm;
            fmn1_reg  <= far_mm - near_mm;
            hr1_reg   <= hr_next;
            w1_reg    <= w_next;
            col1_reg  <= pixel_col;
            err1_reg  <= err_next;
            sp1_reg   <= err_next | dz_next | le_next | ge_next;
            one1_reg  <= err_next | dz_next | !le_next;

            num2_reg  <= far1_reg * dmn1_reg;
            den2_reg  <= fmn1_reg * d1_reg;
            idxm2_reg <= idx_prod[IDX_W-1:0];
            col2_reg  <= col1_reg;
            sp2_reg   <= sp1_reg;
            one2_reg  <= one1_reg;
            err2_reg  <= err1_reg;

            num3_reg           <= num2_reg;
            den3_reg           <= den2_reg;
            side3_reg.idx      <= idxm2_reg + {{(IDX_W-COL_W){1'b0}}, col2_reg};
            side3_reg.special  <= sp2_reg;
            side3_reg.spec_one <= one2_reg;
            side3_reg.err      <= err2_reg;
        end
    end

    assign out_valid = v3_reg;
    assign out_num   = num3_reg;
    assign out_den   = den3_reg;
    assign out_side  = side3_reg;

endmodule

// ===== hw/rtl/dtpz_divider.sv =====
`timescale 1ns / 1ps
module dtpz_divider
    import dtpz_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             en,
    input  logic             in_valid,
    input  logic [NUM_W-1:0] in_num,
    input  logic [NUM_W-1:0] in_den,
    input  side_t            in_side,
    output logic             out_valid,
    output result_t          out_res
);

    localparam logic [Z_W-1:0] Z_ONE = Z_W'(1) << FRAC_BITS;

    logic                 v_reg    [0:FRAC_BITS-1];
    logic [REM_W-1:0]     rem_reg  [0:FRAC_BITS-1];
    logic [NUM_W-1:0]     den_reg  [0:FRAC_BITS-1];
    logic [FRAC_BITS-1:0] q_reg    [0:FRAC_BITS-1];
    side_t                side_reg [0:FRAC_BITS-1];

    logic                 vo_reg;
    result_t              res_reg;

    genvar k;
    generate
        for (k = 0; k < FRAC_BITS; k++) begin : g_step
            logic                 v_in;
            logic [REM_W-1:0]     r_in;
            logic [NUM_W-1:0]     d_in;
            logic [FRAC_BITS-1:0] q_in;
            side_t                s_in;
            logic [REM_W-1:0]     r2;
            logic                 ge;

            if (k == 0) begin : g_first
                assign v_in = in_valid;
                assign r_in = {1'b0, in_num};
                assign d_in = in_den;
                assign q_in = '0;
                assign s_in = in_side;
            end else begin : g_rest
                assign v_in = v_reg[k-1];
                assign r_in = rem_reg[k-1];
                assign d_in = den_reg[k-1];
                assign q_in = q_reg[k-1];
                assign s_in = side_reg[k-1];
            end

            // shift remainder, subtract divisor where it fits
            assign r2 = {r_in[REM_W-2:0], 1'b0};
            assign ge = r2 >= {1'b0, d_in};

            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    v_reg[k] <= 1'b0;
                end else if (en) begin
                    v_reg[k] <= v_in;
                end
            end

            always_ff @(posedge aclk) begin
                if (en) begin
                    rem_reg[k]  <= ge ? (r2 - {1'b0, d_in}) : r2;
                    den_reg[k]  <= d_in;
                    q_reg[k]    <= {q_in[FRAC_BITS-2:0], ge};
                    side_reg[k] <= s_in;
                end
            end
        end
    endgenerate

    localparam int L = FRAC_BITS - 1;

    logic [REM_W-1:0] r2_last;
    logic             round_up;
    logic [Z_W-1:0]   q_round;

    always_comb begin
        r2_last  = {rem_reg[L][REM_W-2:0], 1'b0};
        round_up = r2_last >= {1'b0, den_reg[L]};
        q_round  = {1'b0, q_reg[L]} + {{(Z_W-1){1'b0}}, round_up};
        if (q_round > Z_ONE) begin
            q_round = Z_ONE;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vo_reg <= 1'b0;
        end else if (en) begin
            vo_reg <= v_reg[L];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            if (side_reg[L].special) begin
                res_reg.z <= side_reg[L].spec_one ? Z_ONE : '0;
            end else begin
                res_reg.z <= q_round;
            end
            res_reg.idx <= side_reg[L].idx;
            res_reg.err <= side_reg[L].err;
        end
    end

    assign out_valid = vo_reg;
    assign out_res   = res_reg;

endmodule

// ===== hw/rtl/dtpz_out_buf.sv =====
`timescale 1ns / 1ps
module dtpz_out_buf
    import dtpz_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    in_valid,
    input  result_t in_res,
    output logic    pipe_en,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_res
);

    logic    ov_reg, sk_reg;
    result_t out_reg, skid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ov_reg <= 1'b0;
            sk_reg <= 1'b0;
        end else if (out_ready || !ov_reg) begin
            if (sk_reg) begin
                ov_reg <= 1'b1;
                sk_reg <= 1'b0;
            end else begin
                ov_reg <= in_valid;
            end
        end else if (in_valid && !sk_reg) begin
            // output blocked: park the transfer in the skid slot
            sk_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_ready || !ov_reg) begin
            out_reg <= sk_reg ? skid_reg : in_res;
        end else if (!sk_reg) begin
            skid_reg <= in_res;
        end
    end

    assign pipe_en   = !sk_reg;
    assign out_valid = ov_reg;
    assign out_res   = out_reg;

endmodule

// ===== hw/rtl/depth_to_projected_z.sv =====
`timescale 1ns / 1ps
// Channel    | Dir | Handshake            | Payload
// -----------+-----+----------------------+---------------------------------------
// s_ (pixel) | in  | s_tvalid / s_tready  | s_tdata: depth_raw, pixel_row, pixel_col
// m_ (z)     | out | m_tvalid / m_tready  | m_tdata: z_value, out_index, config_error
// cfg        | in  | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// One pixel per clock sustained while the output is not blocked; 3 setup/multiply
// stages, 24 restoring-division stages and one rounding stage, plus the output register.
// Synchronous active-low reset clears all valid bits; config returns to defaults.
// s_tready and cfg_ready stay low during reset.
// When a result meets a blocked output, the skid slot takes it and the whole
// pipeline freezes from the next cycle; s_tready is a registered signal.
module depth_to_projected_z
    import dtpz_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,  // depth_raw[15:0], pixel_row[25:16], pixel_col[35:26]
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,  // z_value[24:0], out_index[44:25], config_error[45]
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [1:0]            cfg_index,
    input  logic [CLIP_W-1:0]     cfg_data
);

    logic [CLIP_W-1:0] near_reg, far_reg;
    logic [SIZE_W-1:0] width_reg, height_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            near_reg   <= CLIP_W'(500);
            far_reg    <= CLIP_W'(8000);
            width_reg  <= SIZE_W'(640);
            height_reg <= SIZE_W'(480);
        end else if (cfg_valid) begin
            unique case (reg_idx_t'(cfg_index))
                REG_NEAR:   near_reg   <= cfg_data;
                REG_FAR:    far_reg    <= cfg_data;
                REG_WIDTH:  width_reg  <= cfg_data[SIZE_W-1:0];
                REG_HEIGHT: height_reg <= cfg_data[SIZE_W-1:0];
                default: ;
            endcase
        end
    end

    assign cfg_ready = aresetn;

    logic             en;
    logic             p_valid, d_valid;
    logic [NUM_W-1:0] p_num, p_den;
    side_t            p_side;
    result_t          d_res, o_res;

    assign s_tready = en & aresetn;

    dtpz_prep u_prep (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .en           (en),
        .in_valid     (s_tvalid),
        .depth_raw    (s_tdata[15:0]),
        .pixel_row    (s_tdata[25:16]),
        .pixel_col    (s_tdata[35:26]),
        .near_mm      (near_reg),
        .far_mm       (far_reg),
        .image_width  (width_reg),
        .image_height (height_reg),
        .out_valid    (p_valid),
        .out_num      (p_num),
        .out_den      (p_den),
        .out_side     (p_side)
    );

    dtpz_divider u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (p_valid),
        .in_num    (p_num),
        .in_den    (p_den),
        .in_side   (p_side),
        .out_valid (d_valid),
        .out_res   (d_res)
    );

    dtpz_out_buf u_obuf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (d_valid),
        .in_res    (d_res),
        .pipe_en   (en),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (o_res)
    );

    assign m_tdata = {2'b00, o_res.err, o_res.idx, o_res.z};

endmodule

// ===== tb/depth_to_projected_z_tb.sv =====
`timescale 1ns / 1ps
module depth_to_projected_z_tb;
    import dtpz_pkg::*;

    localparam int LIMIT = 20000;
    localparam int DRAIN = 40;

    typedef struct {
        logic [15:0] depth;
        logic [9:0]  row;
        logic [9:0]  col;
        bit          typed;
        logic [24:0] z;
        logic [19:0] idx;
        logic        err;
    } pixel_row_t;

    typedef struct packed {
        logic [24:0] z;
        logic [19:0] idx;
        logic        err;
    } z_result_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [1:0]            cfg_index;
    logic [CLIP_W-1:0]     cfg_data;

    logic [15:0] near_q, far_q;
    logic [10:0] width_q, height_q;
    z_result_t   pending_z[$];
    int          fails;
    int          quiet_cycles;
    bit          hold_req;
    bit          stim_done;

    depth_to_projected_z dut (.*);

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    function automatic z_result_t project_pixel(logic [15:0] raw, logic [9:0] row,
                                                logic [9:0] col);
        z_result_t   r;
        logic [12:0] d;
        logic [63:0] num, den, q, w, h;
        d = raw[15:3];
        w = (width_q > MAX_WIDTH) ? MAX_WIDTH : width_q;
        h = (height_q > MAX_HEIGHT) ? MAX_HEIGHT : height_q;
        r.err = (far_q <= near_q);
        if (r.err || d == 0) begin
            q = 64'd1 << FRAC_BITS;
        end else if (d <= near_q) begin
            q = 0;
        end else if (d >= far_q) begin
            q = 64'd1 << FRAC_BITS;
        end else begin
            num = (64'(far_q) * 64'(d - near_q)) << FRAC_BITS;
            den = 64'(far_q - near_q) * 64'(d);
            q = (num + den / 2) / den;
            if (q > (64'd1 << FRAC_BITS)) q = 64'd1 << FRAC_BITS;
        end
        r.z = q[24:0];
        r.idx = 20'((h - 1 - 64'(row)) * w + 64'(col));
        return r;
    endfunction

    task automatic write_reg(reg_idx_t idx, logic [15:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        case (idx)
            REG_NEAR:   near_q   = value;
            REG_FAR:    far_q    = value;
            REG_WIDTH:  width_q  = value[10:0];
            REG_HEIGHT: height_q = value[10:0];
            default: ;
        endcase
        @(posedge aclk);
    endtask

    task automatic settle;
        s_tvalid <= 1'b0;
        while (pending_z.size() != 0) @(posedge aclk);
        repeat (DRAIN) @(posedge aclk);
    endtask

    task automatic send_pixel(logic [15:0] raw, logic [9:0] row, logic [9:0] col,
                              bit gaps);
        int gap;
        gap = gaps ? $urandom_range(0, 15) : 0;
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'd0, col, row, raw};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pending_z.push_back(project_pixel(raw, row, col));
    endtask

    task automatic random_phase(int count);
        logic [15:0] raw;
        int i;
        for (i = 0; i < count; i++) begin
            case ($urandom_range(0, 5))
                0: raw = 16'($urandom_range(0, 15));
                1: raw = {3'(0), 13'(near_q) + 13'($urandom_range(0, 2))} << 3
                         | 16'($urandom_range(0, 7));
                2: raw = 16'($urandom);
                default: raw = 16'($urandom_range(32'(near_q) << 3,
                                                  (32'(far_q) << 3) | 32'd7));
            endcase
            send_pixel(raw, 10'($urandom), 10'($urandom), $urandom_range(0, 4) != 0);
        end
    endtask

    pixel_row_t directed [10] = '{
        '{16'd0,     10'd0,    10'd0,    1, 25'h1000000, 20'd306560, 1'b0},
        '{16'd7,     10'd479,  10'd639,  1, 25'h1000000, 20'd639,    1'b0},
        '{16'hFFFF,  10'd1023, 10'd1023, 1, 25'h1000000, 20'hAB3FF,  1'b0},
        '{16'd4000,  10'd5,    10'd7,    1, 25'd0,       20'd303367, 1'b0},
        '{16'd4008,  10'd1,    10'd2,    0, 25'd0,       20'd0,      1'b0},
        '{16'd8000,  10'd200,  10'd300,  0, 25'd0,       20'd0,      1'b0},
        '{16'd63992, 10'd100,  10'd100,  0, 25'd0,       20'd0,      1'b0},
        '{16'd64000, 10'd0,    10'd1,    1, 25'h1000000, 20'd306561, 1'b0},
        '{16'h5555,  10'h2AA,  10'h155,  0, 25'd0,       20'd0,      1'b0},
        '{16'hAAAA,  10'h155,  10'h2AA,  0, 25'd0,       20'd0,      1'b0}
    };

    initial begin
        int i;
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        cfg_valid = 1'b0;
        cfg_index = REG_NEAR;
        cfg_data  = '0;
        stim_done = 1'b0;
        hold_req  = 1'b0;
        near_q = 16'd500; far_q = 16'd8000; width_q = 11'd640; height_q = 11'd480;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (i = 0; i < $size(directed); i++) begin
            send_pixel(directed[i].depth, directed[i].row, directed[i].col, 0);
            if (directed[i].typed) begin
                void'(pending_z.pop_back());
                pending_z.push_back('{directed[i].z, directed[i].idx, directed[i].err});
            end
        end
        settle();

        // hold the receiver off long enough that the pipeline backs up into s_tready
        hold_req = 1'b1;
        random_phase(80);
        settle();

        write_reg(REG_FAR, 16'd500);
        send_pixel(16'd4000, 10'd3, 10'd3, 0);
        send_pixel(16'd0, 10'd0, 10'd0, 0);
        settle();

        write_reg(REG_NEAR, 16'd1);
        write_reg(REG_FAR, 16'd65535);
        write_reg(REG_WIDTH, 16'd1024);
        write_reg(REG_HEIGHT, 16'd1024);
        random_phase(180);
        settle();

        write_reg(REG_NEAR, 16'd65535);
        write_reg(REG_FAR, 16'd1);
        write_reg(REG_WIDTH, 16'd2047);
        write_reg(REG_HEIGHT, 16'd2047);
        random_phase(60);
        settle();

        write_reg(REG_NEAR, 16'd100);
        write_reg(REG_FAR, 16'd2000);
        write_reg(REG_WIDTH, 16'd1);
        write_reg(REG_HEIGHT, 16'd1);
        random_phase(180);
        settle();

        for (i = 0; i < 3; i++) begin
            write_reg(REG_NEAR, 16'($urandom_range(1, 4000)));
            write_reg(REG_FAR, 16'($urandom_range(near_q + 1, 8191)));
            write_reg(REG_WIDTH, 16'($urandom_range(1, 1024)));
            write_reg(REG_HEIGHT, 16'($urandom_range(0, 2047)));
            random_phase(120);
            settle();
        end

        stim_done = 1'b1;
        if (fails == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial begin
        int wait_n;
        bit held;
        m_tready = 1'b0;
        held = 1'b0;
        @(posedge aresetn);
        forever begin
            if (hold_req && !held) begin
                held = 1'b1;
                m_tready <= 1'b0;
                repeat (300) @(posedge aclk);
            end
            wait_n = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 15);
            if (wait_n != 0) begin
                m_tready <= 1'b0;
                repeat (wait_n) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
        end
    end

    always @(posedge aclk) begin
        z_result_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got = '{m_tdata[24:0], m_tdata[44:25], m_tdata[45]};
            if (pending_z.size() == 0) begin
                $error("unexpected result z=%0h idx=%0d", got.z, got.idx);
                fails++;
            end else begin
                want = pending_z.pop_front();
                if (got.z !== want.z) begin
                    $error("z_value expected %0h actual %0h", want.z, got.z);
                    fails++;
                end
                if (got.idx !== want.idx) begin
                    $error("out_index expected %0d actual %0d", want.idx, got.idx);
                    fails++;
                end
                if (got.err !== want.err) begin
                    $error("config_error expected %0b actual %0b", want.err, got.err);
                    fails++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= LIMIT && !stim_done) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

endmodule
